FILE: src/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and constants of the binary max-heap core: field widths,
// operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package bmh_pkg;

	// Field widths.
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 11;
	localparam int ST_W   = 2;
	// A heap slot number (1-based), wide enough for twice the largest count.
	localparam int SLOT_W = CNT_W + 1;

	// Default store depth.
	localparam int DEPTH_DEF = 1024;

	// Operation codes.
	localparam logic OP_INSERT     = 1'b0;
	localparam logic OP_DELETE_MAX = 1'b1;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// Configuration register map.
	localparam int                 PADDR_W   = 2;
	localparam logic [PADDR_W-1:0] ADDR_CAP  = 2'd0;
	localparam logic [CNT_W-1:0]   CAP_RESET = 11'd1024;

	// Result record from the sequencer to the output ports.
	typedef struct packed {
		logic                     valid;
		logic [ST_W-1:0]          status;
		logic signed [VAL_W-1:0]  max_value;
	} bmh_result_t;

endpackage

FILE: src/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram
// Heap element store: one write port and two read ports, each read with
// registered data in the cycle after the address.
// ----------------------------------------------------------------------------
module bmh_ram #(
	parameter int DEPTH = bmh_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  logic [AW-1:0]                   rd_addr_a,
	input  logic [AW-1:0]                   rd_addr_b,
	output logic signed [bmh_pkg::VAL_W-1:0] rd_data_a,
	output logic signed [bmh_pkg::VAL_W-1:0] rd_data_b,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   wr_addr,
	input  logic signed [bmh_pkg::VAL_W-1:0] wr_data
);

	logic signed [bmh_pkg::VAL_W-1:0] mem [DEPTH];

	// Synchronous write and two registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

FILE: src/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sift sequencer: holds the element count and walks the heap one level per
// cycle, reading the next level while writing back the current one.
// ----------------------------------------------------------------------------
module bmh_ctrl #(
	parameter int DEPTH = bmh_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             op,
	input  logic signed [bmh_pkg::VAL_W-1:0]  item_value,
	input  logic [bmh_pkg::CNT_W-1:0]         eff_cap,
	output logic                             busy,
	output logic [bmh_pkg::CNT_W-1:0]         count,
	output bmh_pkg::bmh_result_t              result,
	output logic [AW-1:0]                    rd_addr_a,
	output logic [AW-1:0]                    rd_addr_b,
	input  logic signed [bmh_pkg::VAL_W-1:0]  rd_data_a,
	input  logic signed [bmh_pkg::VAL_W-1:0]  rd_data_b,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic signed [bmh_pkg::VAL_W-1:0]  wr_data
);

	localparam int SW = bmh_pkg::SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_UP_ROOT,
		S_DN_LOAD,
		S_DN_CMP,
		S_DN_FIN
	} state_t;

	state_t                           state_q;
	logic [bmh_pkg::CNT_W-1:0]        count_q;
	logic [SW-1:0]                    slot_q;
	logic signed [bmh_pkg::VAL_W-1:0] val_q;
	bmh_pkg::bmh_result_t             result_q;

	logic [SW-1:0]                    count_slot;
	logic [SW-1:0]                    slot_ins;
	logic [SW-1:0]                    up_next;
	logic                             up_move;
	logic [SW-1:0]                    child_l;
	logic                             pick_r;
	logic [SW-1:0]                    child;
	logic signed [bmh_pkg::VAL_W-1:0] child_val;
	logic                             dn_move;
	logic [SW-1:0]                    child_next;
	logic                             accept;
	logic                             ins_full;
	logic [SW-1:0]                    rd_slot_a;
	logic [SW-1:0]                    rd_slot_b;
	logic [SW-1:0]                    wr_slot;

	// Slot numbers are 1-based; the store is addressed from zero.
	function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] s);
		logic [SW-1:0] d;
		d = (s == '0) ? '0 : s - SW'(1);
		return AW'(d);
	endfunction

	// Comparisons and next slots for both sift directions.
	always_comb begin
		accept     = start && (state_q == S_IDLE);
		ins_full   = (count_q >= eff_cap);
		count_slot = SW'(count_q);
		slot_ins   = count_slot + SW'(1);
		up_next    = slot_q >> 1;
		up_move    = (rd_data_a < val_q);
		child_l    = slot_q << 1;
		pick_r     = (child_l < count_slot) && (rd_data_a < rd_data_b);
		child      = pick_r ? (child_l + SW'(1)) : child_l;
		child_val  = pick_r ? rd_data_b : rd_data_a;
		dn_move    = (val_q < child_val);
		child_next = child << 1;
	end

	// Memory read and write requests.
	always_comb begin
		rd_slot_a = '0;
		rd_slot_b = '0;
		wr_en     = 1'b0;
		wr_slot   = slot_q;
		wr_data   = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (op == bmh_pkg::OP_INSERT) begin
					rd_slot_a = slot_ins >> 1;
					wr_en     = accept && !ins_full && (count_q == '0);
					wr_slot   = SW'(1);
					wr_data   = item_value;
				end else begin
					rd_slot_a = SW'(1);
					rd_slot_b = count_slot;
				end
			end
			S_UP_CMP: begin
				rd_slot_a = up_next >> 1;
				wr_en     = 1'b1;
				wr_data   = up_move ? rd_data_a : val_q;
			end
			S_UP_ROOT: begin
				wr_en = 1'b1;
			end
			S_DN_LOAD: begin
				rd_slot_a = child_l;
				rd_slot_b = child_l + SW'(1);
			end
			S_DN_CMP: begin
				rd_slot_a = child_next;
				rd_slot_b = child_next + SW'(1);
				wr_en     = 1'b1;
				wr_data   = dn_move ? child_val : val_q;
			end
			S_DN_FIN: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_addr_a = to_addr(rd_slot_a);
	assign rd_addr_b = to_addr(rd_slot_b);
	assign wr_addr   = to_addr(wr_slot);

	// Sequencer state, count and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			slot_q         <= '0;
			val_q          <= '0;
			result_q       <= '0;
		end else begin
			result_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_q.max_value <= '0;
						if (op == bmh_pkg::OP_INSERT) begin
							if (ins_full) begin
								result_q.valid  <= 1'b1;
								result_q.status <= bmh_pkg::ST_FULL;
							end else begin
								count_q <= count_q + bmh_pkg::CNT_W'(1);
								slot_q  <= slot_ins;
								val_q   <= item_value;
								if (count_q == '0) begin
									// First element goes straight to the root.
									result_q.valid  <= 1'b1;
									result_q.status <= bmh_pkg::ST_OK;
								end else begin
									state_q <= S_UP_CMP;
								end
							end
						end else begin
							if (count_q == '0) begin
								result_q.valid  <= 1'b1;
								result_q.status <= bmh_pkg::ST_EMPTY;
							end else begin
								count_q <= count_q - bmh_pkg::CNT_W'(1);
								slot_q  <= SW'(1);
								state_q <= S_DN_LOAD;
							end
						end
					end
				end
				S_UP_CMP: begin
					if (up_move) begin
						// Parent moved down; continue one level higher.
						slot_q <= up_next;
						if (up_next == SW'(1)) begin
							state_q <= S_UP_ROOT;
						end
					end else begin
						result_q.valid  <= 1'b1;
						result_q.status <= bmh_pkg::ST_OK;
						state_q         <= S_IDLE;
					end
				end
				S_UP_ROOT: begin
					result_q.valid  <= 1'b1;
					result_q.status <= bmh_pkg::ST_OK;
					state_q         <= S_IDLE;
				end
				S_DN_LOAD: begin
					// Root is the removed maximum, the old last element sifts down.
					result_q.max_value <= rd_data_a;
					val_q              <= rd_data_b;
					if (count_q == '0) begin
						result_q.valid  <= 1'b1;
						result_q.status <= bmh_pkg::ST_OK;
						state_q         <= S_IDLE;
					end else if (child_l > count_slot) begin
						state_q <= S_DN_FIN;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (dn_move) begin
						slot_q <= child;
						if (child_next > count_slot) begin
							state_q <= S_DN_FIN;
						end
					end else begin
						result_q.valid  <= 1'b1;
						result_q.status <= bmh_pkg::ST_OK;
						state_q         <= S_IDLE;
					end
				end
				S_DN_FIN: begin
					result_q.valid  <= 1'b1;
					result_q.status <= bmh_pkg::ST_OK;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign count  = count_q;
	assign result = result_q;

endmodule

FILE: src/binary_max_heap_core.sv
// ----------------------------------------------------------------------------
// binary_max_heap_core
// Binary max-heap priority queue of signed 32-bit values in a block memory.
// ----------------------------------------------------------------------------
// Usage:
// - A command transaction is taken when start is high and busy is low. op
//   selects insert of item_value or removal of the maximum.
// - Each command yields one result transaction: done is high for exactly one
//   cycle with status, max_value and element_count. The receiver cannot
//   stall it; a new command may be issued in the same cycle done is shown.
// - A full insert, an insert into an empty heap or an empty delete reports in
//   the cycle after the command. A delete that empties the heap reports from
//   S_DN_LOAD. Other inserts pass S_UP_CMP once per level the value climbs,
//   then S_UP_ROOT if it reaches the root; other deletes pass S_DN_LOAD, then
//   S_DN_CMP once per level the old last element sinks, then S_DN_FIN if it
//   reaches the bottom. Each level reads the next one while writing the
//   current one back, as set by the registered reads of the element store.
// - The APB port holds capacity_limit at address 0; write it only while idle.
// - Reset empties the heap and sets capacity_limit to 1024. The element store
//   is not cleared; data read from unwritten slots is never used.
// ----------------------------------------------------------------------------
module binary_max_heap_core #(
	parameter int DEPTH = bmh_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bmh_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// Command channel.
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [bmh_pkg::VAL_W-1:0]   item_value,
	// Result channel.
	output logic                              done,
	output logic [bmh_pkg::ST_W-1:0]           status,
	output logic signed [bmh_pkg::VAL_W-1:0]   max_value,
	output logic [bmh_pkg::CNT_W-1:0]          element_count
);

	localparam int AW          = $clog2(DEPTH);
	localparam int CNT_MAX     = (2 ** bmh_pkg::CNT_W) - 1;
	localparam int DEPTH_CAP_I = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
	localparam logic [bmh_pkg::CNT_W-1:0] DEPTH_CAP = bmh_pkg::CNT_W'(DEPTH_CAP_I);

	logic [bmh_pkg::CNT_W-1:0]        cap_q;
	logic [bmh_pkg::CNT_W-1:0]        eff_cap;
	bmh_pkg::bmh_result_t             result;
	logic [AW-1:0]                    rd_addr_a;
	logic [AW-1:0]                    rd_addr_b;
	logic signed [bmh_pkg::VAL_W-1:0] rd_data_a;
	logic signed [bmh_pkg::VAL_W-1:0] rd_data_b;
	logic                             wr_en;
	logic [AW-1:0]                    wr_addr;
	logic signed [bmh_pkg::VAL_W-1:0] wr_data;

	// Capacity register, written by a completed APB write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bmh_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == bmh_pkg::ADDR_CAP)) begin
			cap_q <= pwdata[bmh_pkg::CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == bmh_pkg::ADDR_CAP) ? 32'(cap_q) : '0;

	// The heap is full at the smaller of the limit and the store depth.
	assign eff_cap = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;

	bmh_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.item_value (item_value),
		.eff_cap    (eff_cap),
		.busy       (busy),
		.count      (element_count),
		.result     (result),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	bmh_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Result ports.
	assign done      = result.valid;
	assign status    = result.status;
	assign max_value = result.max_value;

endmodule

FILE: src/bmh_checker.sv
// ----------------------------------------------------------------------------
// bmh_checker
// Port-level checks of the heap core, attached to every instance by bind.
// ----------------------------------------------------------------------------
module bmh_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [bmh_pkg::ST_W-1:0]           status,
	input logic signed [bmh_pkg::VAL_W-1:0]   max_value,
	input logic [bmh_pkg::CNT_W-1:0]          element_count
);

	// An accepted command either reports next cycle or keeps the core busy.
	a_cmd_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("command accepted but neither busy nor done");

	// A failed command (full or empty) returns a maximum of zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != bmh_pkg::ST_OK) |-> max_value == '0)
		else $error("failed transaction returned a nonzero value");

	// An empty delete reports a count of zero.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == bmh_pkg::ST_EMPTY) |-> element_count == '0)
		else $error("empty status with nonzero count");

	// The count holds while the core is idle and no command arrives.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> $stable(element_count))
		else $error("count changed while idle");

endmodule

bind binary_max_heap_core bmh_checker u_bmh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.max_value     (max_value),
	.element_count (element_count)
);
